@@ hdl/complex_arithmetic_unit_assert.svh @@
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// checked only out of reset
`define CAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/cau_pkg.sv @@
`timescale 1ns / 1ps

package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int Q_STEPS   = DATA_W;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] mag;
    } t_sm;

    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] val;
    } t_sat;

    typedef struct packed {
        logic                     valid;
        t_op                      op;
        logic signed [DATA_W:0]   sr;
        logic signed [DATA_W:0]   si;
        logic                     nre;
        logic                     nim;
        logic [PROD_W-1:0]        mre;
        logic [PROD_W-1:0]        mim;
        logic [PROD_W-1:0]        den;
        logic                     dz;
    } t_front;

    typedef struct packed {
        logic                     valid;
        t_op                      op;
        logic signed [DATA_W:0]   sr;
        logic signed [DATA_W:0]   si;
        logic                     nre;
        logic                     nim;
        logic [PROD_W-1:0]        mre;
        logic [PROD_W-1:0]        mim;
        logic [PROD_W-1:0]        den;
        logic                     dz;
        logic                     bigr;
        logic                     bigi;
        logic [PROD_W-1:0]        remr;
        logic [PROD_W-1:0]        remi;
        logic [DATA_W-1:0]        qr;
        logic [DATA_W-1:0]        qi;
    } t_dstage;

    function automatic t_sm sm_add(input logic n1, input logic [PROD_W-1:0] m1,
                                   input logic n2, input logic [PROD_W-1:0] m2);
        t_sm r;
        if (n1 == n2) begin
            r.neg = n1;
            r.mag = m1 + m2;
        end else if (m1 >= m2) begin
            r.neg = n1;
            r.mag = m1 - m2;
        end else begin
            r.neg = n2;
            r.mag = m2 - m1;
        end
        if (r.mag == '0) begin
            r.neg = 1'b0;
        end
        return r;
    endfunction

    function automatic t_sat saturate(input logic neg, input logic [PROD_W-1:0] mag);
        t_sat r;
        r.ovf = 1'b0;
        if (!neg) begin
            if (mag > PROD_W'({1'b0, {(DATA_W-1){1'b1}}})) begin
                r.ovf = 1'b1;
                r.val = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                r.val = mag[DATA_W-1:0];
            end
        end else begin
            if (mag > PROD_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
                r.ovf = 1'b1;
                r.val = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                r.val = DATA_W'(0) - mag[DATA_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

@@ hdl/complex_arithmetic_unit.sv @@
`timescale 1ns / 1ps

// Complex add, subtract, multiply and divide on signed Q16.16 operands.
// Fully pipelined: one item per clock unless the output stalls.
// The depth is set by the divider: three stages of operand
// preparation and multiplication, then 33 divider stages (a range
// check, then one quotient bit per stage for 32 stages), then the
// output register. All operations travel the same pipeline, so
// results leave in order. When a valid output is stalled the whole
// pipeline holds and o_stall is raised toward the source.

module complex_arithmetic_unit import cau_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_action,
    input  logic signed [DATA_W-1:0] i_a_real,
    input  logic signed [DATA_W-1:0] i_a_imag,
    input  logic signed [DATA_W-1:0] i_b_real,
    input  logic signed [DATA_W-1:0] i_b_imag,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_res_real,
    output logic signed [DATA_W-1:0] o_res_imag,
    output logic                     o_div_zero,
    output logic                     o_overflow
);

    logic              en;
    t_front            front;
    t_dstage           back;
    t_sat              sat_r, sat_i;
    logic              n_dz;
    logic [DATA_W:0]   as_mr, as_mi;

    logic              r_valid;
    logic [DATA_W-1:0] r_res_real, r_res_imag;
    logic              r_div_zero, r_overflow;

    assign en      = !r_valid || !i_stall;
    assign o_stall = !en;

    cau_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_a_real (i_a_real),
        .i_a_imag (i_a_imag),
        .i_b_real (i_b_real),
        .i_b_imag (i_b_imag),
        .o_front  (front)
    );

    cau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_front (front),
        .o_back  (back)
    );

    assign as_mr = back.sr[DATA_W] ? (DATA_W+1)'(-back.sr) : back.sr;
    assign as_mi = back.si[DATA_W] ? (DATA_W+1)'(-back.si) : back.si;

    always_comb begin
        n_dz = 1'b0;
        case (back.op)
            OP_ADD, OP_SUB: begin
                sat_r = saturate(back.sr[DATA_W], PROD_W'(as_mr));
                sat_i = saturate(back.si[DATA_W], PROD_W'(as_mi));
            end
            OP_MUL: begin
                sat_r = saturate(back.nre, back.mre >> FRAC_BITS);
                sat_i = saturate(back.nim, back.mim >> FRAC_BITS);
            end
            OP_DIV: begin
                if (back.dz) begin
                    n_dz  = 1'b1;
                    sat_r = '0;
                    sat_i = '0;
                end else begin
                    sat_r = saturate(back.nre,
                        back.bigr ? (PROD_W'(1) << DATA_W) : PROD_W'(back.qr));
                    sat_i = saturate(back.nim,
                        back.bigi ? (PROD_W'(1) << DATA_W) : PROD_W'(back.qi));
                end
            end
            default: begin
                sat_r = '0;
                sat_i = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= back.valid;
        end
        if (en) begin
            r_res_real <= sat_r.val;
            r_res_imag <= sat_i.val;
            r_div_zero <= n_dz;
            r_overflow <= sat_r.ovf | sat_i.ovf;
        end
    end

    assign o_valid    = r_valid;
    assign o_res_real = r_res_real;
    assign o_res_imag = r_res_imag;
    assign o_div_zero = r_div_zero;
    assign o_overflow = r_overflow;

`include "complex_arithmetic_unit_assert.svh"

    `CAU_ASSERT(a_dz_no_ovf, (o_valid && o_div_zero) |-> !o_overflow, "div by zero with overflow")
    `CAU_ASSERT(a_dz_zero, (o_valid && o_div_zero) |-> (o_res_real == '0 && o_res_imag == '0), "div by zero result not zero")
    `CAU_ASSERT(a_stall_cause, o_stall |-> (o_valid && i_stall), "input stalled without held output")
    `CAU_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

@@ hdl/cau_front.sv @@
`timescale 1ns / 1ps

module cau_front import cau_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [1:0]               i_action,
    input  logic signed [DATA_W-1:0] i_a_real,
    input  logic signed [DATA_W-1:0] i_a_imag,
    input  logic signed [DATA_W-1:0] i_b_real,
    input  logic signed [DATA_W-1:0] i_b_imag,
    output t_front                   o_front
);

    // stage 1: signs, magnitudes, add/sub
    logic                   r1_valid;
    t_op                    r1_op;
    logic [DATA_W-1:0]      r1_mar, r1_mai, r1_mbr, r1_mbi;
    logic                   r1_nar, r1_nai, r1_nbr, r1_nbi;
    logic signed [DATA_W:0] r1_sr, r1_si;

    // stage 2: products
    logic                   r2_valid;
    t_op                    r2_op;
    logic                   r2_nar, r2_nai, r2_nbr, r2_nbi;
    logic signed [DATA_W:0] r2_sr, r2_si;
    logic [PROD_W-1:0]      r2_prr, r2_pii, r2_pri, r2_pir, r2_qr, r2_qi;

    // stage 3: signed sums, divisor
    t_front                 r3;
    t_front                 n3;
    t_op                    n1_op;
    t_sm                    sm_re, sm_im;

    assign n1_op = t_op'(i_action);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_op  <= n1_op;
            r1_nar <= i_a_real[DATA_W-1];
            r1_nai <= i_a_imag[DATA_W-1];
            r1_nbr <= i_b_real[DATA_W-1];
            r1_nbi <= i_b_imag[DATA_W-1];
            r1_mar <= i_a_real[DATA_W-1] ? DATA_W'(-i_a_real) : i_a_real;
            r1_mai <= i_a_imag[DATA_W-1] ? DATA_W'(-i_a_imag) : i_a_imag;
            r1_mbr <= i_b_real[DATA_W-1] ? DATA_W'(-i_b_real) : i_b_real;
            r1_mbi <= i_b_imag[DATA_W-1] ? DATA_W'(-i_b_imag) : i_b_imag;
            if (n1_op == OP_SUB) begin
                r1_sr <= {i_a_real[DATA_W-1], i_a_real} - {i_b_real[DATA_W-1], i_b_real};
                r1_si <= {i_a_imag[DATA_W-1], i_a_imag} - {i_b_imag[DATA_W-1], i_b_imag};
            end else begin
                r1_sr <= {i_a_real[DATA_W-1], i_a_real} + {i_b_real[DATA_W-1], i_b_real};
                r1_si <= {i_a_imag[DATA_W-1], i_a_imag} + {i_b_imag[DATA_W-1], i_b_imag};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_op  <= r1_op;
            r2_nar <= r1_nar;
            r2_nai <= r1_nai;
            r2_nbr <= r1_nbr;
            r2_nbi <= r1_nbi;
            r2_sr  <= r1_sr;
            r2_si  <= r1_si;
            r2_prr <= r1_mar * r1_mbr;
            r2_pii <= r1_mai * r1_mbi;
            r2_pri <= r1_mar * r1_mbi;
            r2_pir <= r1_mai * r1_mbr;
            r2_qr  <= r1_mbr * r1_mbr;
            r2_qi  <= r1_mbi * r1_mbi;
        end
    end

    always_comb begin
        if (r2_op == OP_DIV) begin
            sm_re = sm_add(r2_nar ^ r2_nbr, r2_prr, r2_nai ^ r2_nbi, r2_pii);
            sm_im = sm_add(r2_nai ^ r2_nbr, r2_pir, !(r2_nar ^ r2_nbi), r2_pri);
        end else begin
            sm_re = sm_add(r2_nar ^ r2_nbr, r2_prr, !(r2_nai ^ r2_nbi), r2_pii);
            sm_im = sm_add(r2_nar ^ r2_nbi, r2_pri, r2_nai ^ r2_nbr, r2_pir);
        end
        n3.valid = r2_valid;
        n3.op    = r2_op;
        n3.sr    = r2_sr;
        n3.si    = r2_si;
        n3.nre   = sm_re.neg;
        n3.mre   = sm_re.mag;
        n3.nim   = sm_im.neg;
        n3.mim   = sm_im.mag;
        n3.den   = r2_qr + r2_qi;
        n3.dz    = (r2_qr == '0) && (r2_qi == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3.valid <= 1'b0;
        end else if (i_en) begin
            r3 <= n3;
        end
    end

    assign o_front = r3;

endmodule

@@ hdl/cau_div.sv @@
`timescale 1ns / 1ps

module cau_div import cau_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_front  i_front,
    output t_dstage o_back
);

    t_dstage r_st [0:Q_STEPS];
    t_dstage n_st0;

    // partial remainder starts as the numerator bits above the quotient field
    always_comb begin
        n_st0.valid = i_front.valid;
        n_st0.op    = i_front.op;
        n_st0.sr    = i_front.sr;
        n_st0.si    = i_front.si;
        n_st0.nre   = i_front.nre;
        n_st0.nim   = i_front.nim;
        n_st0.mre   = i_front.mre;
        n_st0.mim   = i_front.mim;
        n_st0.den   = i_front.den;
        n_st0.dz    = i_front.dz;
        n_st0.remr  = i_front.mre >> (Q_STEPS - FRAC_BITS);
        n_st0.remi  = i_front.mim >> (Q_STEPS - FRAC_BITS);
        n_st0.bigr  = (i_front.mre >> (Q_STEPS - FRAC_BITS)) >= i_front.den;
        n_st0.bigi  = (i_front.mim >> (Q_STEPS - FRAC_BITS)) >= i_front.den;
        n_st0.qr    = '0;
        n_st0.qi    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].valid <= 1'b0;
        end else if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    for (genvar k = 1; k <= Q_STEPS; k++) begin : g_step
        localparam int J = Q_STEPS - k;
        logic          bit_r, bit_i;
        logic [PROD_W:0] t_r, t_i;
        logic          ge_r, ge_i;
        t_dstage       n_st;

        if (J >= FRAC_BITS) begin : g_num
            assign bit_r = r_st[k-1].mre[J-FRAC_BITS];
            assign bit_i = r_st[k-1].mim[J-FRAC_BITS];
        end else begin : g_zero
            assign bit_r = 1'b0;
            assign bit_i = 1'b0;
        end

        always_comb begin
            t_r  = {r_st[k-1].remr, bit_r};
            t_i  = {r_st[k-1].remi, bit_i};
            ge_r = t_r >= {1'b0, r_st[k-1].den};
            ge_i = t_i >= {1'b0, r_st[k-1].den};
            n_st = r_st[k-1];
            n_st.remr = ge_r ? PROD_W'(t_r - {1'b0, r_st[k-1].den}) : t_r[PROD_W-1:0];
            n_st.remi = ge_i ? PROD_W'(t_i - {1'b0, r_st[k-1].den}) : t_i[PROD_W-1:0];
            n_st.qr[J] = ge_r;
            n_st.qi[J] = ge_i;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].valid <= 1'b0;
            end else if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_back = r_st[Q_STEPS];

endmodule
